[design/tcw_pkg.sv]
// Shared constants, item types and a helper function for the text console cell writer.
`default_nettype none

package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;

    localparam int COL_W  = $clog2(COLUMNS + 1);
    localparam int ROW_W  = $clog2(ROWS + 1);
    localparam int IDX_W  = $clog2(COLUMNS * ROWS + 1);
    localparam int STEP_W = 4;

    localparam logic [31:0] SCREEN_BASE_RESET = 32'h000B_8000;
    localparam logic [7:0]  TEXT_COLOR_RESET  = 8'h07;

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_X       = 8'h78;
    localparam logic [7:0] CHAR_A       = 8'h41;

    localparam logic [STEP_W-1:0] STEP_FIRST     = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_PREFIX_X  = STEP_W'(1);
    localparam logic [STEP_W-1:0] STEP_LAST_BYTE = STEP_W'(1);
    localparam logic [STEP_W-1:0] STEP_LAST_WORD = STEP_W'(9);

    typedef enum logic [2:0] {
        CMD_PUT_CHAR = 3'd0,
        CMD_HEX_BYTE = 3'd1,
        CMD_HEX_WORD = 3'd2,
        CMD_CLEAR    = 3'd3,
        CMD_SET_POS  = 3'd4
    } t_cmd;

    typedef enum logic {
        REG_TEXT_COLOR  = 1'b0,
        REG_SCREEN_BASE = 1'b1
    } t_reg_index;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  char_code;
        logic [31:0] hex_value;
        logic [7:0]  pos_x;
        logic [7:0]  pos_y;
    } t_in_item;

    typedef struct packed {
        logic [31:0] write_address;
        logic [15:0] cell_value;
        logic        clear_all;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic newline;
        logic set_pos;
        logic reduce;
        logic emit;
    } t_ctl_cmd;

    typedef struct packed {
        logic out_free;
        logic emit_last;
        logic reduce_done;
    } t_dp_status;

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        logic [7:0] d;
        if (n <= 4'd9) begin
            d = CHAR_ZERO + 8'(n);
        end else begin
            d = CHAR_A + 8'(n - 4'd10);
        end
        return d;
    endfunction

endpackage

`default_nettype wire

[design/tcw_ctrl.sv]
// Controller state machine that sequences input items into cell writes.
`default_nettype none

module tcw_ctrl import tcw_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [2:0] i_command,
    input  wire logic [7:0] i_char_code,
    input  wire t_dp_status i_status,
    output logic            o_in_ready,
    output t_ctl_cmd        o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EMIT,
        S_REDUCE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    priority if (i_command == CMD_PUT_CHAR && i_char_code == CHAR_NEWLINE) begin
                        o_cmd.newline = 1'b1;
                    end else if (i_command == CMD_PUT_CHAR || i_command == CMD_HEX_BYTE ||
                                 i_command == CMD_HEX_WORD || i_command == CMD_CLEAR) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_EMIT;
                    end else if (i_command == CMD_SET_POS) begin
                        o_cmd.set_pos = 1'b1;
                        n_state       = S_REDUCE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.emit_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_REDUCE: begin
                o_cmd.reduce = 1'b1;
                if (i_status.reduce_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_emit_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_status.out_free)
        else $error("emit issued while the output register is occupied");

    a_emit_leaves_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && o_cmd.emit && i_status.emit_last) |=> (r_state == S_IDLE))
        else $error("controller did not return to idle after the last result");

    a_load_enters_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_EMIT))
        else $error("loaded item did not start emitting");

endmodule

`default_nettype wire

[design/tcw_datapath.sv]
// Datapath holding the cursor, configuration registers and the output register.
`default_nettype none

module tcw_datapath import tcw_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_in_item    i_in,
    input  wire t_ctl_cmd    i_cmd,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_out_ready,
    output t_dp_status       o_status,
    output logic             o_out_valid,
    output t_out_item        o_out
);

    logic [7:0]        r_text_color;
    logic [31:0]       r_screen_base;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [IDX_W-1:0]  r_idx;
    logic [2:0]        r_cmd;
    logic [7:0]        r_char;
    logic [31:0]       r_hex;
    logic [STEP_W-1:0] r_step;
    logic [7:0]        r_red_col;
    logic [8:0]        r_red_row;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [7:0]        emit_char;
    logic              emit_shift;
    logic [STEP_W-1:0] last_step;
    logic              is_clear;
    logic [ROW_W-1:0]  next_row;
    logic              col_over;
    logic              row_over;

    assign is_clear = (r_cmd == CMD_CLEAR);
    assign next_row = (r_row == ROW_W'(ROWS - 1)) ? '0 : r_row + ROW_W'(1);
    assign col_over = (r_red_col >= 8'(COLUMNS));
    assign row_over = (r_red_row >= 9'(ROWS));

    always_comb begin
        emit_char  = r_char;
        emit_shift = 1'b0;
        last_step  = STEP_FIRST;
        unique case (r_cmd)
            CMD_PUT_CHAR: begin
                emit_char = r_char;
            end
            CMD_HEX_BYTE: begin
                emit_char  = hex_digit(r_hex[31:28]);
                emit_shift = 1'b1;
                last_step  = STEP_LAST_BYTE;
            end
            CMD_HEX_WORD: begin
                last_step = STEP_LAST_WORD;
                priority if (r_step == STEP_FIRST) begin
                    emit_char = CHAR_ZERO;
                end else if (r_step == STEP_PREFIX_X) begin
                    emit_char = CHAR_X;
                end else begin
                    emit_char  = hex_digit(r_hex[31:28]);
                    emit_shift = 1'b1;
                end
            end
            default: begin
                emit_char = '0;
            end
        endcase
    end

    assign o_status.out_free    = !r_out_valid || i_out_ready;
    assign o_status.emit_last   = (r_step == last_step);
    assign o_status.reduce_done = !col_over && !row_over;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color  <= TEXT_COLOR_RESET;
            r_screen_base <= SCREEN_BASE_RESET;
            r_col         <= '0;
            r_row         <= '0;
            r_idx         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_TEXT_COLOR:  r_text_color  <= i_cfg_data[7:0];
                    REG_SCREEN_BASE: r_screen_base <= i_cfg_data;
                    default:         r_text_color  <= r_text_color;
                endcase
            end

            if (i_cmd.newline) begin
                r_col <= '0;
                r_row <= next_row;
                r_idx <= IDX_W'(next_row * COLUMNS);
            end

            if (i_cmd.reduce && !col_over && !row_over) begin
                r_col <= r_red_col[COL_W-1:0];
                r_row <= r_red_row[ROW_W-1:0];
                r_idx <= IDX_W'(r_red_row[ROW_W-1:0] * COLUMNS) + IDX_W'(r_red_col);
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                if (is_clear) begin
                    r_col <= '0;
                    r_row <= '0;
                    r_idx <= '0;
                end else if (r_col == COL_W'(COLUMNS - 1)) begin
                    r_col <= '0;
                    r_row <= next_row;
                    r_idx <= (r_idx == IDX_W'(COLUMNS * ROWS - 1)) ? '0 : r_idx + IDX_W'(1);
                end else begin
                    r_col <= r_col + COL_W'(1);
                    r_idx <= r_idx + IDX_W'(1);
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= i_in.command;
            r_char <= i_in.char_code;
            r_step <= STEP_FIRST;
            r_hex  <= (i_in.command == CMD_HEX_BYTE) ? {i_in.hex_value[7:0], 24'h0}
                                                     : i_in.hex_value;
        end else if (i_cmd.emit) begin
            r_step <= r_step + STEP_W'(1);
            if (emit_shift) begin
                r_hex <= {r_hex[27:0], 4'h0};
            end
        end

        if (i_cmd.set_pos) begin
            r_red_col <= i_in.pos_x;
            r_red_row <= {1'b0, i_in.pos_y};
        end else if (i_cmd.reduce) begin
            if (col_over) begin
                r_red_col <= r_red_col - 8'(COLUMNS);
                r_red_row <= r_red_row + 9'd1;
            end else if (row_over) begin
                r_red_row <= r_red_row - 9'(ROWS);
            end
        end

        if (i_cmd.emit) begin
            r_out.clear_all     <= is_clear;
            r_out.last          <= o_status.emit_last;
            r_out.write_address <= is_clear ? r_screen_base
                                            : r_screen_base + 32'({r_idx, 1'b0});
            r_out.cell_value    <= is_clear ? 16'h0 : {r_text_color, emit_char};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= COL_W'(COLUMNS - 1))
        else $error("cursor column out of range");

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= ROW_W'(ROWS - 1))
        else $error("cursor row out of range");

    a_index_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx == IDX_W'(r_row * COLUMNS) + IDX_W'(r_col))
        else $error("cell index disagrees with the cursor");

    a_clear_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.clear_all) |-> r_out.last)
        else $error("clear result not flagged as last");

endmodule

`default_nettype wire

[design/text_console_cell_writer.sv]
// Top level of the text console cell writer: controller plus datapath.
`default_nettype none

// Turns console commands into cell writes for a COLUMNS x ROWS text buffer, one result item per
// cell with its byte address, attribute and character, or a single clear item for a clear. An
// item is taken while the block is idle; each result then passes through the output register,
// and no new item is taken until the last result is registered, however long the consumer
// stalls. Newline and unknown commands finish in the accept cycle. Set position runs a subtract
// loop in the datapath that takes COLUMNS off for each column wrap and ROWS for each row wrap.
// No clearing pass follows reset.
module text_console_cell_writer import tcw_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in_item    i_in,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_item        o_out,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    t_ctl_cmd   ctl_cmd;
    t_dp_status dp_status;

    tcw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_command   (i_in.command),
        .i_char_code (i_in.char_code),
        .i_status    (dp_status),
        .o_in_ready  (o_in_ready),
        .o_cmd       (ctl_cmd)
    );

    tcw_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (ctl_cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_status    (dp_status),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

[tb/tcw_cell_checker.sv]
// Checker that predicts the cell writes of the text console cell writer and compares them.
`timescale 1ns / 100ps

module tcw_cell_checker import tcw_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  t_in_item         i_in,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  t_out_item        i_out,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    output int               o_mismatches,
    output int               o_pending
);

    logic [7:0]       attr;
    logic [31:0]      base_addr;
    logic [COL_W-1:0] cur_col;
    logic [ROW_W-1:0] cur_row;
    logic [IDX_W-1:0] cur_idx;
    t_out_item        cell_queue[$];
    int               mismatches = 0;

    assign o_mismatches = mismatches;

    function automatic logic [7:0] glyph(input logic [3:0] n);
        if (n < 4'd10) begin
            return CHAR_ZERO + 8'(n);
        end
        return CHAR_A + 8'(n) - 8'd10;
    endfunction

    task automatic move_cursor(input int c, input int r);
        int rr;
        rr = (r + c / COLUMNS) % ROWS;
        cur_col = COL_W'(c % COLUMNS);
        cur_row = ROW_W'(rr);
        cur_idx = IDX_W'(rr * COLUMNS + c % COLUMNS);
    endtask

    task automatic put_glyph(input logic [7:0] ch, input logic fin);
        t_out_item wr;
        wr.write_address = base_addr + (32'(cur_idx) << 1);
        wr.cell_value    = {attr, ch};
        wr.clear_all     = 1'b0;
        wr.last          = fin;
        cell_queue.push_back(wr);
        move_cursor(int'(cur_col) + 1, int'(cur_row));
    endtask

    task automatic render_command(input t_in_item cmd);
        t_out_item wr;
        case (cmd.command)
            CMD_PUT_CHAR: begin
                if (cmd.char_code == CHAR_NEWLINE) begin
                    move_cursor(0, int'(cur_row) + 1);
                end else begin
                    put_glyph(cmd.char_code, 1'b1);
                end
            end
            CMD_HEX_BYTE: begin
                put_glyph(glyph(cmd.hex_value[7:4]), 1'b0);
                put_glyph(glyph(cmd.hex_value[3:0]), 1'b1);
            end
            CMD_HEX_WORD: begin
                put_glyph(CHAR_ZERO, 1'b0);
                put_glyph(CHAR_X, 1'b0);
                for (int n = 7; n >= 0; n--) begin
                    put_glyph(glyph(cmd.hex_value[4*n +: 4]), n == 0);
                end
            end
            CMD_CLEAR: begin
                wr.write_address = base_addr;
                wr.cell_value    = '0;
                wr.clear_all     = 1'b1;
                wr.last          = 1'b1;
                cell_queue.push_back(wr);
                move_cursor(0, 0);
            end
            CMD_SET_POS: begin
                move_cursor(int'(cmd.pos_x), int'(cmd.pos_y));
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_cell(input t_out_item got);
        t_out_item want;
        if (cell_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("Unexpected cell write: address %h value %h clear %b last %b",
                         got.write_address, got.cell_value, got.clear_all, got.last);
            end
            return;
        end
        want = cell_queue.pop_front();
        if (got.write_address !== want.write_address || got.cell_value !== want.cell_value ||
                got.clear_all !== want.clear_all || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("Cell mismatch: expected address %h value %h clear %b last %b",
                         want.write_address, want.cell_value, want.clear_all, want.last);
                $display("               actual   address %h value %h clear %b last %b",
                         got.write_address, got.cell_value, got.clear_all, got.last);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            attr      = TEXT_COLOR_RESET;
            base_addr = SCREEN_BASE_RESET;
            cur_col   = '0;
            cur_row   = '0;
            cur_idx   = '0;
            cell_queue.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_TEXT_COLOR) begin
                    attr = i_cfg_data[7:0];
                end else begin
                    base_addr = i_cfg_data;
                end
            end
            if (i_out_valid && i_out_ready) begin
                check_cell(i_out);
            end
            if (i_in_valid && i_in_ready) begin
                render_command(i_in);
            end
        end
        o_pending = cell_queue.size();
    end

endmodule

[tb/text_console_cell_writer_tb.sv]
// Testbench top for the text console cell writer: stimulus, configuration phases and verdict.
`timescale 1ns / 100ps

module text_console_cell_writer_tb;
    import tcw_pkg::*;

    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 32;
    localparam int PHASE_ITEMS   = 68;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in        = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out;
    logic        i_cfg_we    = 1'b0;
    logic        i_cfg_index = REG_TEXT_COLOR;
    logic [31:0] i_cfg_data  = '0;
    logic        steady      = 1'b0;
    int          mismatches;
    int          pending;
    int          quiet_cycles = 0;

    text_console_cell_writer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    tcw_cell_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in         (i_in),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out        (o_out),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always #6 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(99, 0) >= 10);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL text_console_cell_writer");
            $finish;
        end
    end

    function automatic t_in_item make_item(input logic [2:0] cmd, input logic [7:0] ch,
                                           input logic [31:0] hv, input logic [7:0] px,
                                           input logic [7:0] py);
        t_in_item it;
        it.command   = cmd;
        it.char_code = ch;
        it.hex_value = hv;
        it.pos_x     = px;
        it.pos_y     = py;
        return it;
    endfunction

    task automatic push_command(input t_in_item it);
        while (!steady && $urandom_range(99, 0) < 10) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in       <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_index idx, input logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic random_item(output t_in_item it, output bit ignored);
        int pick;
        it.char_code = 8'($urandom);
        it.hex_value = $urandom;
        it.pos_x     = 8'($urandom);
        it.pos_y     = 8'($urandom);
        ignored      = 1'b0;
        pick         = $urandom_range(99, 0);
        if (pick < 40) begin
            it.command = CMD_PUT_CHAR;
        end else if (pick < 47) begin
            it.command   = CMD_PUT_CHAR;
            it.char_code = CHAR_NEWLINE;
        end else if (pick < 62) begin
            it.command = CMD_HEX_BYTE;
        end else if (pick < 72) begin
            it.command = CMD_HEX_WORD;
        end else if (pick < 76) begin
            it.command = CMD_CLEAR;
        end else if (pick < 92) begin
            it.command = CMD_SET_POS;
            if (pick < 84) begin
                it.pos_x = 8'($urandom_range(COLUMNS - 1, COLUMNS - 10));
                it.pos_y = 8'(ROWS - 1);
            end
        end else begin
            it.command = 3'(int'(CMD_SET_POS) + $urandom_range(3, 1));
            ignored    = 1'b1;
        end
    endtask

    initial begin
        t_in_item it;
        bit       ignored;
        int       sent;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed items under the reset configuration.
        push_command(make_item(CMD_PUT_CHAR, CHAR_A, $urandom, 8'($urandom), 8'($urandom)));
        push_command(make_item(CMD_PUT_CHAR, 8'h00, $urandom, 8'($urandom), 8'($urandom)));
        push_command(make_item(CMD_PUT_CHAR, 8'hFF, $urandom, 8'($urandom), 8'($urandom)));
        push_command(make_item(CMD_PUT_CHAR, CHAR_NEWLINE, $urandom, 8'h00, 8'h00));
        push_command(make_item(CMD_HEX_BYTE, 8'h00, 32'hFFFF_FF00, 8'hFF, 8'hFF));
        push_command(make_item(CMD_HEX_BYTE, 8'hFF, 32'h0000_00FF, 8'h00, 8'h00));
        push_command(make_item(CMD_HEX_BYTE, 8'($urandom), 32'h1234_56A5, 8'h00, 8'h00));
        push_command(make_item(CMD_HEX_WORD, 8'($urandom), 32'h0000_0000, 8'h00, 8'h00));
        push_command(make_item(CMD_HEX_WORD, 8'($urandom), 32'hFFFF_FFFF, 8'h00, 8'h00));
        push_command(make_item(CMD_HEX_WORD, 8'($urandom), 32'h0123_4567, 8'h00, 8'h00));
        push_command(make_item(CMD_HEX_WORD, 8'($urandom), 32'h89AB_CDEF, 8'h00, 8'h00));
        push_command(make_item(CMD_CLEAR, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF));
        push_command(make_item(CMD_SET_POS, 8'h00, 32'h0, 8'h00, 8'h00));
        push_command(make_item(CMD_SET_POS, 8'h00, 32'h0, 8'(COLUMNS - 1), 8'(ROWS - 1)));
        push_command(make_item(CMD_PUT_CHAR, CHAR_X, 32'h0, 8'h00, 8'h00));
        push_command(make_item(CMD_SET_POS, 8'h00, 32'h0, 8'(COLUMNS - 1), 8'd3));
        push_command(make_item(CMD_PUT_CHAR, CHAR_ZERO, 32'h0, 8'h00, 8'h00));
        push_command(make_item(CMD_SET_POS, 8'h00, 32'h0, 8'hFF, 8'hFF));
        push_command(make_item(CMD_PUT_CHAR, CHAR_A, 32'h0, 8'h00, 8'h00));
        push_command(make_item(CMD_SET_POS, 8'h00, 32'h0, 8'(COLUMNS), 8'h00));
        push_command(make_item(CMD_SET_POS, 8'h00, 32'h0, 8'd5, 8'(ROWS - 1)));
        push_command(make_item(CMD_PUT_CHAR, CHAR_NEWLINE, 32'h0, 8'h00, 8'h00));
        push_command(make_item(CMD_SET_POS, 8'h00, 32'h0, 8'(COLUMNS - 2), 8'(ROWS - 1)));
        push_command(make_item(CMD_HEX_WORD, 8'h00, $urandom, 8'h00, 8'h00));
        for (int k = 1; k <= 3; k++) begin
            push_command(make_item(3'(int'(CMD_SET_POS) + k), 8'($urandom), $urandom,
                                   8'($urandom), 8'($urandom)));
        end
        push_command(make_item(CMD_PUT_CHAR, CHAR_A, 32'h0, 8'h00, 8'h00));

        for (int phase = 1; phase <= 4; phase++) begin
            drain();
            case (phase)
                1: begin
                    write_reg(REG_TEXT_COLOR, 32'h0000_0000);
                    write_reg(REG_SCREEN_BASE, 32'h0000_0000);
                end
                2: begin
                    write_reg(REG_TEXT_COLOR, 32'h0000_00FF);
                    write_reg(REG_SCREEN_BASE, 32'hFFFF_FFFF);
                end
                3: begin
                    write_reg(REG_TEXT_COLOR, $urandom);
                    write_reg(REG_SCREEN_BASE, 32'hFFFF_F800);
                end
                default: begin
                    write_reg(REG_TEXT_COLOR, $urandom);
                    write_reg(REG_SCREEN_BASE, $urandom);
                end
            endcase
            steady = (phase == 2);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                random_item(it, ignored);
                push_command(it);
                if (!ignored) begin
                    sent++;
                end
            end
        end
        steady = 1'b0;
        drain();

        if (mismatches == 0) begin
            $display("PASS text_console_cell_writer");
        end else begin
            $display("FAIL text_console_cell_writer");
        end
        $finish;
    end

endmodule
